>>> hdl/vsla_pkg.sv
// Shared types and constants for the velocity slew limiter and averager.
// Holds configuration layout, datapath command codes and controller states.
// Depends on nothing.
package vsla_pkg;

   localparam int NUM_AGENTS_DEFAULT = 8;
   localparam int MAX_WINDOW_DEFAULT = 16;
   localparam int VEL_WIDTH_DEFAULT  = 16;

   localparam int STEP_LIMIT_W  = 15;
   localparam int WINDOW_LEN_W  = 5;
   localparam int AGENT_IN_W    = 3;
   localparam int CSR_DATA_W    = 15;
   localparam int CSR_INDEX_W   = 2;

   localparam logic [STEP_LIMIT_W-1:0] STEP_LIMIT_RESET = 15'd256;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_STEP_LIMIT    = 2'd0,
      CSR_LIMIT_ENABLE  = 2'd1,
      CSR_WINDOW_LENGTH = 2'd2,
      CSR_WEIGHTED_MODE = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [STEP_LIMIT_W-1:0] step_limit;
      logic                    limit_enable;
      logic [WINDOW_LEN_W-1:0] window_length;
      logic                    weighted_mode;
   } cfg_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_DIFF,
      OP_SQUARE,
      OP_SQRT_INIT,
      OP_SQRT_STEP,
      OP_PROD,
      OP_SDIV,
      OP_SAPPLY,
      OP_WINDOW,
      OP_WRITE,
      OP_RADDR,
      OP_RACC,
      OP_ADIV,
      OP_AAPPLY,
      OP_OUT
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic [1:0] comp;
   } dp_cmd_type;

   typedef struct packed {
      logic limit_hit;
      logic win_zero;
      logic sqrt_last;
      logic div_last;
      logic walk_last;
   } dp_stat_type;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_DIFF,
      ST_SQUARE,
      ST_CHECK,
      ST_SQRT_INIT,
      ST_SQRT_RUN,
      ST_PROD,
      ST_SDIV_GO,
      ST_SDIV_WAIT,
      ST_SAPPLY,
      ST_WINDOW,
      ST_WRITE,
      ST_RADDR,
      ST_RACC,
      ST_ADIV_GO,
      ST_ADIV_WAIT,
      ST_AAPPLY,
      ST_OUT
   } ctrl_state_type;

endpackage

>>> hdl/vsla_div.sv
// Restoring divider, one quotient bit per cycle.
// Used by the datapath for both the step scaling and the average.
// Depends on nothing outside this file.
module vsla_div #(
   parameter int NUM_W = 40,
   parameter int DEN_W = 25
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [NUM_W-1:0] quo,
   output logic             last
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [DEN_W:0]   trial;

   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign last  = busy_ff && (cnt_ff == CNT_W'(NUM_W - 1));
   assign quo   = quo_ff;

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         quo_in  = num;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = DEN_W'(trial - {1'b0, den_ff});
            quo_in = {quo_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DEN_W-1:0];
            quo_in = {quo_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 1'b1;
         if (last) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

endmodule

>>> hdl/vsla_dpath.sv
// Datapath: per-agent state, sample ring memory, square root and averaging.
// Executes one command per cycle from the controller.
// Depends on vsla_pkg and vsla_div.
module vsla_dpath import vsla_pkg::*; #(
   parameter int NUM_AGENTS = NUM_AGENTS_DEFAULT,
   parameter int MAX_WINDOW = MAX_WINDOW_DEFAULT,
   parameter int VEL_WIDTH  = VEL_WIDTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  cfg_type                     cfg,
   input  dp_cmd_type                  cmd,
   output dp_stat_type                 stat,
   input  logic [AGENT_IN_W-1:0]       req_agent,
   input  logic signed [VEL_WIDTH-1:0] req_vel_x,
   input  logic signed [VEL_WIDTH-1:0] req_vel_y,
   input  logic signed [VEL_WIDTH-1:0] req_vel_z,
   output logic signed [VEL_WIDTH-1:0] rsp_out_x,
   output logic signed [VEL_WIDTH-1:0] rsp_out_y,
   output logic signed [VEL_WIDTH-1:0] rsp_out_z
);

   localparam int VW       = VEL_WIDTH;
   localparam int DW       = VW + 1;
   localparam int D2_W     = 2 * VW + 2;
   localparam int CMP_W    = (D2_W > 2 * STEP_LIMIT_W) ? D2_W : 2 * STEP_LIMIT_W;
   localparam int ROOT_W   = VW + 9;
   localparam int X_W      = 2 * ROOT_W;
   localparam int RCNT_W   = $clog2(ROOT_W + 1);
   localparam int PROD_W   = DW + STEP_LIMIT_W + 1;
   localparam int NUM_W    = VW + 24;
   localparam int CNT_W    = $clog2(MAX_WINDOW + 1);
   localparam int SLOT_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int WSUM_MAX = MAX_WINDOW * (MAX_WINDOW + 1) / 2;
   localparam int WS_W     = $clog2(WSUM_MAX + 1);
   localparam int ACC_W    = VW + WS_W + 1;
   localparam int TERM_W   = VW + CNT_W + 1;
   localparam int AGENT_W  = (NUM_AGENTS > 1) ? $clog2(NUM_AGENTS) : 1;
   localparam int DEPTH    = NUM_AGENTS * MAX_WINDOW;
   localparam int MEM_AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SUM_W    = NUM_W + 2;
   localparam logic signed [SUM_W-1:0] SAT_HI = {{(SUM_W-VW+1){1'b0}}, {(VW-1){1'b1}}};
   localparam logic signed [SUM_W-1:0] SAT_LO = {{(SUM_W-VW+1){1'b1}}, {(VW-1){1'b0}}};

   function automatic logic signed [VW-1:0] sat_vel(input logic signed [SUM_W-1:0] val);
      logic signed [VW-1:0] res;
      if (val > SAT_HI) begin
         res = SAT_HI[VW-1:0];
      end else if (val < SAT_LO) begin
         res = SAT_LO[VW-1:0];
      end else begin
         res = val[VW-1:0];
      end
      return res;
   endfunction

   function automatic logic [SLOT_W-1:0] wrap_slot(input logic [CNT_W:0] s);
      logic [CNT_W:0] r;
      r = s;
      if (r >= (CNT_W+1)'(MAX_WINDOW)) begin
         r = r - (CNT_W+1)'(MAX_WINDOW);
      end
      return r[SLOT_W-1:0];
   endfunction

   // Per-agent state.
   logic signed [VW-1:0] last_ff   [NUM_AGENTS][3];
   logic [CNT_W-1:0]     count_ff  [NUM_AGENTS];
   logic [SLOT_W-1:0]    oldest_ff [NUM_AGENTS];
   logic [3*VW-1:0]      ring_mem  [DEPTH];

   // Item registers.
   logic [AGENT_W-1:0]    agent_ff;
   logic [AGENT_W-1:0]    agent_in;
   logic signed [VW-1:0]  v_ff [3];
   logic signed [DW-1:0]  d_ff [3];
   logic [D2_W-1:0]       d2_ff;
   logic [X_W-1:0]        x_ff;
   logic [ROOT_W-1:0]     rem_ff;
   logic [ROOT_W-1:0]     root_ff;
   logic [RCNT_W-1:0]     rcnt_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic                  sign_ff;
   logic [CNT_W-1:0]      cnt_ff;
   logic [CNT_W-1:0]      k_ff;
   logic [SLOT_W-1:0]     old_ff;
   logic [SLOT_W-1:0]     slot_ff;
   logic signed [ACC_W-1:0] acc_ff [3];
   logic [WS_W-1:0]       wsum_ff;
   logic [3*VW-1:0]       rd_ff;
   logic signed [VW-1:0]  out_ff [3];

   // Combinational helpers.
   logic [6:0]              agent_tmp;
   logic [2*STEP_LIMIT_W-1:0] lim_sq;
   logic signed [D2_W-1:0]  sq;
   logic [ROOT_W+1:0]       r_try;
   logic [ROOT_W+1:0]       trial;
   logic [ROOT_W-1:0]       den_n;
   logic [PROD_W-1:0]       prod_mag;
   logic [ACC_W-1:0]        acc_mag;
   logic [NUM_W-1:0]        div_num;
   logic [ROOT_W-1:0]       div_den;
   logic                    div_start;
   logic [NUM_W-1:0]        quo;
   logic                    div_last;
   logic signed [SUM_W-1:0] quo_s;
   logic signed [SUM_W-1:0] step_sum;
   logic [CNT_W-1:0]        w_eff;
   logic [CNT_W-1:0]        cnt0, cnt1, cnt_new;
   logic [SLOT_W-1:0]       old1, old_new, slot_new;
   logic [CNT_W-1:0]        wt;
   logic signed [VW-1:0]    rd_elem [3];
   logic signed [TERM_W-1:0] term [3];
   logic [MEM_AW-1:0]       wr_addr, rd_addr;

   // Agent index modulo the agent count, by repeated subtraction.
   always_comb begin
      agent_tmp = 7'(req_agent);
      for (int j = 0; j < 8; j++) begin
         if (agent_tmp >= 7'(NUM_AGENTS)) begin
            agent_tmp = agent_tmp - 7'(NUM_AGENTS);
         end
      end
      agent_in = AGENT_W'(agent_tmp);
   end

   assign lim_sq = cfg.step_limit * cfg.step_limit;
   assign sq     = d_ff[cmd.comp] * d_ff[cmd.comp];

   // One digit pair of the square root per cycle.
   assign r_try = {rem_ff, x_ff[X_W-1 -: 2]};
   assign trial = {root_ff, 2'b01};
   assign den_n = (root_ff == '0) ? ROOT_W'(1) : root_ff;

   assign prod_mag = prod_ff[PROD_W-1] ? PROD_W'(-prod_ff) : PROD_W'(prod_ff);
   assign acc_mag  = acc_ff[cmd.comp][ACC_W-1] ? ACC_W'(-acc_ff[cmd.comp])
                                               : ACC_W'(acc_ff[cmd.comp]);

   always_comb begin
      div_start = 1'b0;
      div_num   = '0;
      div_den   = '1;
      case (cmd.op)
         OP_SDIV: begin
            div_start = 1'b1;
            div_num   = (NUM_W'(prod_mag) << 8) + NUM_W'(den_n >> 1);
            div_den   = den_n;
         end
         OP_ADIV: begin
            div_start = 1'b1;
            div_num   = NUM_W'(acc_mag) + NUM_W'(wsum_ff >> 1);
            div_den   = ROOT_W'(wsum_ff);
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   vsla_div #(
      .NUM_W (NUM_W),
      .DEN_W (ROOT_W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .quo   (quo),
      .last  (div_last)
   );

   assign quo_s    = sign_ff ? -SUM_W'(quo) : SUM_W'(quo);
   assign step_sum = SUM_W'(last_ff[agent_ff][cmd.comp]) + quo_s;

   // Window bookkeeping: drop surplus samples, then pick the slot to fill.
   always_comb begin
      if ({3'b000, cfg.window_length} > 8'(MAX_WINDOW)) begin
         w_eff = CNT_W'(MAX_WINDOW);
      end else begin
         w_eff = CNT_W'(cfg.window_length);
      end
      cnt0 = count_ff[agent_ff];
      cnt1 = cnt0;
      old1 = oldest_ff[agent_ff];
      if (cnt0 > w_eff) begin
         old1 = wrap_slot((CNT_W+1)'(oldest_ff[agent_ff]) + (CNT_W+1)'(cnt0)
                          - (CNT_W+1)'(w_eff));
         cnt1 = w_eff;
      end
      if (cnt1 < w_eff) begin
         slot_new = wrap_slot((CNT_W+1)'(old1) + (CNT_W+1)'(cnt1));
         cnt_new  = cnt1 + 1'b1;
         old_new  = old1;
      end else begin
         slot_new = old1;
         cnt_new  = cnt1;
         old_new  = wrap_slot((CNT_W+1)'(old1) + (CNT_W+1)'(1));
      end
   end

   assign wt      = cfg.weighted_mode ? (k_ff + 1'b1) : CNT_W'(1);
   assign wr_addr = MEM_AW'(agent_ff) * MEM_AW'(MAX_WINDOW) + MEM_AW'(slot_ff);
   assign rd_addr = MEM_AW'(agent_ff) * MEM_AW'(MAX_WINDOW)
                  + MEM_AW'(wrap_slot((CNT_W+1)'(old_ff) + (CNT_W+1)'(k_ff)));

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         rd_elem[c] = rd_ff[c*VW +: VW];
         term[c]    = rd_elem[c] * $signed({1'b0, wt});
      end
   end

   assign stat.limit_hit = cfg.limit_enable && (CMP_W'(d2_ff) > CMP_W'(lim_sq));
   assign stat.win_zero  = (w_eff == '0);
   assign stat.sqrt_last = (rcnt_ff == RCNT_W'(ROOT_W - 1));
   assign stat.div_last  = div_last;
   assign stat.walk_last = ((CNT_W+1)'(k_ff) + 1'b1) == (CNT_W+1)'(cnt_ff);

   // Item datapath registers.
   always_ff @(posedge clock) begin
      case (cmd.op)
         OP_LOAD: begin
            agent_ff <= agent_in;
            v_ff[0]  <= req_vel_x;
            v_ff[1]  <= req_vel_y;
            v_ff[2]  <= req_vel_z;
         end
         OP_DIFF: begin
            for (int c = 0; c < 3; c++) begin
               d_ff[c] <= DW'(v_ff[c]) - DW'(last_ff[agent_ff][c]);
            end
            d2_ff <= '0;
         end
         OP_SQUARE: begin
            d2_ff <= d2_ff + D2_W'(sq);
         end
         OP_SQRT_INIT: begin
            x_ff    <= X_W'(d2_ff) << 16;
            rem_ff  <= '0;
            root_ff <= '0;
            rcnt_ff <= '0;
         end
         OP_SQRT_STEP: begin
            x_ff    <= x_ff << 2;
            rcnt_ff <= rcnt_ff + 1'b1;
            if (r_try >= trial) begin
               rem_ff  <= ROOT_W'(r_try - trial);
               root_ff <= {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               rem_ff  <= r_try[ROOT_W-1:0];
               root_ff <= {root_ff[ROOT_W-2:0], 1'b0};
            end
         end
         OP_PROD: begin
            prod_ff <= d_ff[cmd.comp] * $signed({1'b0, cfg.step_limit});
         end
         OP_SDIV: begin
            sign_ff <= prod_ff[PROD_W-1];
         end
         OP_SAPPLY: begin
            v_ff[cmd.comp] <= sat_vel(step_sum);
         end
         OP_WINDOW: begin
            cnt_ff  <= cnt_new;
            old_ff  <= old_new;
            slot_ff <= slot_new;
            k_ff    <= '0;
            wsum_ff <= '0;
            for (int c = 0; c < 3; c++) begin
               acc_ff[c] <= '0;
            end
         end
         OP_RACC: begin
            for (int c = 0; c < 3; c++) begin
               acc_ff[c] <= acc_ff[c] + ACC_W'(term[c]);
            end
            wsum_ff <= wsum_ff + WS_W'(wt);
            k_ff    <= k_ff + 1'b1;
         end
         OP_ADIV: begin
            sign_ff <= acc_ff[cmd.comp][ACC_W-1];
         end
         OP_AAPPLY: begin
            v_ff[cmd.comp] <= sat_vel(quo_s);
         end
         OP_OUT: begin
            for (int c = 0; c < 3; c++) begin
               out_ff[c] <= v_ff[c];
            end
         end
         default: begin
         end
      endcase
   end

   // Sample ring: one write or one registered read per cycle.
   always_ff @(posedge clock) begin
      if (cmd.op == OP_WRITE) begin
         ring_mem[wr_addr] <= {v_ff[2], v_ff[1], v_ff[0]};
      end
      if (cmd.op == OP_RADDR) begin
         rd_ff <= ring_mem[rd_addr];
      end
   end

   // Per-agent state cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < NUM_AGENTS; a++) begin
            count_ff[a]  <= '0;
            oldest_ff[a] <= '0;
            for (int c = 0; c < 3; c++) begin
               last_ff[a][c] <= '0;
            end
         end
      end else begin
         if (cmd.op == OP_WINDOW) begin
            count_ff[agent_ff]  <= cnt_new;
            oldest_ff[agent_ff] <= old_new;
         end
         if (cmd.op == OP_OUT) begin
            for (int c = 0; c < 3; c++) begin
               last_ff[agent_ff][c] <= v_ff[c];
            end
         end
      end
   end

   assign rsp_out_x = out_ff[0];
   assign rsp_out_y = out_ff[1];
   assign rsp_out_z = out_ff[2];

endmodule

>>> hdl/vsla_ctrl.sv
// Controller state machine: sequences limiting, ring update and averaging.
// Drives datapath commands and the two channel handshakes.
// Depends on vsla_pkg.
module vsla_ctrl import vsla_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   ctrl_state_type state_ff, state_in;
   logic [1:0]     comp_ff, comp_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Next state.
   always_comb begin
      state_in     = state_ff;
      comp_in      = comp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_DIFF;
            end
         end
         ST_DIFF: begin
            comp_in  = 2'd0;
            state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            if (comp_ff == 2'd2) begin
               comp_in  = 2'd0;
               state_in = ST_CHECK;
            end else begin
               comp_in = comp_ff + 2'd1;
            end
         end
         ST_CHECK: begin
            state_in = stat.limit_hit ? ST_SQRT_INIT : ST_WINDOW;
         end
         ST_SQRT_INIT: begin
            state_in = ST_SQRT_RUN;
         end
         ST_SQRT_RUN: begin
            if (stat.sqrt_last) begin
               comp_in  = 2'd0;
               state_in = ST_PROD;
            end
         end
         ST_PROD: begin
            state_in = ST_SDIV_GO;
         end
         ST_SDIV_GO: begin
            state_in = ST_SDIV_WAIT;
         end
         ST_SDIV_WAIT: begin
            if (stat.div_last) begin
               state_in = ST_SAPPLY;
            end
         end
         ST_SAPPLY: begin
            if (comp_ff == 2'd2) begin
               comp_in  = 2'd0;
               state_in = ST_WINDOW;
            end else begin
               comp_in  = comp_ff + 2'd1;
               state_in = ST_PROD;
            end
         end
         ST_WINDOW: begin
            comp_in = 2'd0;
            if (stat.win_zero) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            state_in = ST_RADDR;
         end
         ST_RADDR: begin
            state_in = ST_RACC;
         end
         ST_RACC: begin
            state_in = stat.walk_last ? ST_ADIV_GO : ST_RADDR;
         end
         ST_ADIV_GO: begin
            state_in = ST_ADIV_WAIT;
         end
         ST_ADIV_WAIT: begin
            if (stat.div_last) begin
               state_in = ST_AAPPLY;
            end
         end
         ST_AAPPLY: begin
            if (comp_ff == 2'd2) begin
               comp_in  = 2'd0;
               state_in = ST_OUT;
            end else begin
               comp_in  = comp_ff + 2'd1;
               state_in = ST_ADIV_GO;
            end
         end
         ST_OUT: begin
            // The averaged vector is complete; wait for the result slot.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Command outputs.
   always_comb begin
      cmd.op   = OP_NONE;
      cmd.comp = comp_ff;
      case (state_ff)
         ST_IDLE:      cmd.op = req_valid ? OP_LOAD : OP_NONE;
         ST_DIFF:      cmd.op = OP_DIFF;
         ST_SQUARE:    cmd.op = OP_SQUARE;
         ST_SQRT_INIT: cmd.op = OP_SQRT_INIT;
         ST_SQRT_RUN:  cmd.op = OP_SQRT_STEP;
         ST_PROD:      cmd.op = OP_PROD;
         ST_SDIV_GO:   cmd.op = OP_SDIV;
         ST_SAPPLY:    cmd.op = OP_SAPPLY;
         ST_WINDOW: begin
            if (stat.win_zero) begin
               cmd.op = out_free ? OP_OUT : OP_NONE;
            end else begin
               cmd.op = OP_WINDOW;
            end
         end
         ST_WRITE:     cmd.op = OP_WRITE;
         ST_RADDR:     cmd.op = OP_RADDR;
         ST_RACC:      cmd.op = OP_RACC;
         ST_ADIV_GO:   cmd.op = OP_ADIV;
         ST_AAPPLY:    cmd.op = OP_AAPPLY;
         ST_OUT:       cmd.op = out_free ? OP_OUT : OP_NONE;
         default:      cmd.op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         comp_ff      <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         comp_ff      <= comp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> hdl/velocity_slew_limit_and_average.sv
// Velocity slew limiter with per-agent moving average.
// Top level: configuration registers, controller, datapath, assertions.
// Depends on vsla_pkg, vsla_ctrl and vsla_dpath.

// Each item carries an agent index and a signed Q7.8 velocity vector. With
// limiting enabled, a change from that agent's last result longer than the
// step limit is cut back to exactly the step limit along the change
// direction. The vector then enters the agent's sample ring, and the result
// is the plain or linearly weighted mean of the newest window_length
// samples (window_length 0 passes the vector through). The block works on
// one item at a time; req_stall is low only while it is idle. The cost of an
// item is set by the shared restoring divider, one quotient bit per cycle
// (VEL_WIDTH+24 bits), and by the bit-serial square root. Limiting adds
// one square root and one division per component; averaging adds a read
// walk over the samples in the window and one division per component.
// The sample ring needs no clearing pass after reset: only entries that
// were written since reset are ever read. A finished result sits in an
// output register; the next item is accepted while it waits.
// Configuration must only be written while the block is idle.
module velocity_slew_limit_and_average import vsla_pkg::*; #(
   parameter int NUM_AGENTS = NUM_AGENTS_DEFAULT,
   parameter int MAX_WINDOW = MAX_WINDOW_DEFAULT,
   parameter int VEL_WIDTH  = VEL_WIDTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [AGENT_IN_W-1:0]       req_agent,
   input  logic signed [VEL_WIDTH-1:0] req_vel_x,
   input  logic signed [VEL_WIDTH-1:0] req_vel_y,
   input  logic signed [VEL_WIDTH-1:0] req_vel_z,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [VEL_WIDTH-1:0] rsp_out_x,
   output logic signed [VEL_WIDTH-1:0] rsp_out_y,
   output logic signed [VEL_WIDTH-1:0] rsp_out_z,
   input  logic                        csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]      csr_index,
   input  logic [CSR_DATA_W-1:0]       csr_wdata
);

   cfg_type     cfg_ff, cfg_in;
   dp_cmd_type  cmd;
   dp_stat_type stat;

   // Configuration registers. Each write updates one field of the set.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_STEP_LIMIT:    cfg_in.step_limit    = csr_wdata[STEP_LIMIT_W-1:0];
            CSR_LIMIT_ENABLE:  cfg_in.limit_enable  = csr_wdata[0];
            CSR_WINDOW_LENGTH: cfg_in.window_length = csr_wdata[WINDOW_LEN_W-1:0];
            CSR_WEIGHTED_MODE: cfg_in.weighted_mode = csr_wdata[0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.step_limit    <= STEP_LIMIT_RESET;
         cfg_ff.limit_enable  <= 1'b0;
         cfg_ff.window_length <= '0;
         cfg_ff.weighted_mode <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // The controller sequences the work of one item.
   vsla_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath holds all per-agent state and the arithmetic units.
   vsla_dpath #(
      .NUM_AGENTS (NUM_AGENTS),
      .MAX_WINDOW (MAX_WINDOW),
      .VEL_WIDTH  (VEL_WIDTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd       (cmd),
      .stat      (stat),
      .req_agent (req_agent),
      .req_vel_x (req_vel_x),
      .req_vel_y (req_vel_y),
      .req_vel_z (req_vel_z),
      .rsp_out_x (rsp_out_x),
      .rsp_out_y (rsp_out_y),
      .rsp_out_z (rsp_out_z)
   );

   // An accepted item keeps the block busy for at least the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("block idle right after accepting an item");

   // The block only returns to idle by handing over a result.
   assert property (@(posedge clock) disable iff (reset)
      ($fell(req_stall) && !$past(reset)) |-> rsp_valid)
      else $error("item finished without a result");

   // An idle block never produces a result on its own.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && !req_stall) |=> !rsp_valid)
      else $error("result appeared while idle");

endmodule
